// File: hw/rtl/bmse_pkg.sv
// Package for the byte match similarity engine.
// Holds widths, register and operation codes and the staged item type.
// No dependencies; the lane, merging stage, top level and testbench import it.
`default_nettype none
package bmse_pkg;

	localparam int LANES      = 8;
	localparam int BYTE_W     = 8;
	localparam int WORD_W     = LANES * BYTE_W;
	localparam int IDX_W      = 32;
	localparam int WPV_W      = 10;
	localparam int SCORE_W    = 13;
	localparam int CNT_W      = $clog2(LANES + 1);
	localparam int OUT_DATA_W = ((2 * IDX_W + SCORE_W + 7) / 8) * 8;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 32;

	localparam logic [SCORE_W-1:0] SCORE_MAX = {SCORE_W{1'b1}};
	localparam logic [WPV_W-1:0]   WPV_RESET = WPV_W'(32);

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_WORDS_PER_VECTOR = 2'd0,
		CFG_QUERY_BASE       = 2'd1,
		CFG_DB_BASE          = 2'd2,
		CFG_DB_ROWS          = 2'd3
	} cfg_reg_t;

	typedef enum logic {
		OP_LOAD    = 1'b0,
		OP_COMPARE = 1'b1
	} op_t;

	typedef struct packed {
		op_t               op;
		logic              last;
		logic              batch_last;
		logic [IDX_W-1:0]  query_index;
		logic [IDX_W-1:0]  db_index;
		logic [WORD_W-1:0] data_word;
	} item_t;

endpackage
`default_nettype wire

// File: hw/rtl/bmse_ram.sv
// Generic single-port-write, single-port-read RAM with a registered read.
// Width and depth are parameters; no dependencies. Contents are undefined until written.
`default_nettype none
module bmse_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 512
) (
	input  wire                                       clk,
	input  wire                                       we,
	input  wire [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  wire [WIDTH-1:0]                           wdata,
	input  wire                                       re,
	input  wire [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                          rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule
`default_nettype wire

// File: hw/rtl/bmse_lane.sv
// One byte lane: compares a query byte with a database byte.
// Depends on bmse_pkg for the byte width.
`default_nettype none
module bmse_lane (
	input  wire [bmse_pkg::BYTE_W-1:0] query_byte,
	input  wire [bmse_pkg::BYTE_W-1:0] db_byte,
	output logic                       match
);

	import bmse_pkg::*;

	assign match = (query_byte == db_byte);

endmodule
`default_nettype wire

// File: hw/rtl/bmse_merge.sv
// Merging stage: counts the lane matches of one word and adds them to the running score.
// The sum saturates at the top of the score range. Depends on bmse_pkg.
`default_nettype none
module bmse_merge (
	input  wire [bmse_pkg::LANES-1:0]   lane_match,
	input  wire [bmse_pkg::SCORE_W-1:0] acc,
	output logic [bmse_pkg::SCORE_W-1:0] score
);

	import bmse_pkg::*;

	logic [CNT_W-1:0]   count;
	logic [SCORE_W:0]   sum;

	always_comb begin
		count = '0;
		for (int i = 0; i < LANES; i++) begin
			count = count + CNT_W'(lane_match[i]);
		end
		sum = {1'b0, acc} + (SCORE_W + 1)'(count);
		if (sum > (SCORE_W + 1)'(SCORE_MAX)) begin
			score = SCORE_MAX;
		end else begin
			score = sum[SCORE_W-1:0];
		end
	end

endmodule
`default_nettype wire

// File: hw/rtl/byte_match_similarity_engine.sv
// Top level of the byte match similarity engine: configuration registers, query store,
// eight byte lanes, merging stage and the output register. Depends on bmse_pkg, bmse_ram,
// bmse_lane and bmse_merge.
//
// Each input beat is registered into the compare stage while the query word at the current
// position is read from the query store (or the beat's word is written into it); from that
// register the eight lanes compare bytes and the merging stage updates the score. One beat is
// in flight at a time, so no new beat is taken until the staged one leaves, and a staged result
// waits there while the output register is full. A result sits in an output register, so the
// next beat is taken while it waits. There is no clearing pass after reset.
`default_nettype none
module byte_match_similarity_engine #(
	parameter int MAX_VECTOR_WORDS = 512
) (
	input  wire                                clk,
	input  wire                                arst_n,
	input  wire                                s_tvalid,
	output logic                               s_tready,
	input  wire [bmse_pkg::WORD_W-1:0]         s_tdata,  // data_word
	input  wire                                s_tuser,  // opcode
	output logic                               m_tvalid,
	input  wire                                m_tready,
	output logic [bmse_pkg::OUT_DATA_W-1:0]    m_tdata,  // query_index, db_index, score
	output logic                               m_tlast,  // batch_last
	input  wire                                cfg_valid,
	output logic                               cfg_ready,
	input  wire [bmse_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  wire [bmse_pkg::CFG_DATA_W-1:0]     cfg_data
);

	import bmse_pkg::*;

	localparam int POS_W   = (MAX_VECTOR_WORDS > 1) ? $clog2(MAX_VECTOR_WORDS) : 1;
	localparam int MAXL_W  = $clog2(MAX_VECTOR_WORDS + 1);
	localparam int LEN_W   = (MAXL_W > WPV_W) ? MAXL_W : WPV_W;

	logic [WPV_W-1:0]   wpv_q;
	logic [IDX_W-1:0]   qbase_q;
	logic [IDX_W-1:0]   dbbase_q;
	logic [IDX_W-1:0]   dbrows_q;
	logic [POS_W-1:0]   pos_q;
	logic [SCORE_W-1:0] score_q;
	logic [IDX_W-1:0]   qcnt_q;
	logic [IDX_W-1:0]   dbcnt_q;

	logic               valid_s1;
	item_t              item_s1;

	logic               m_valid_q;
	logic [IDX_W-1:0]   m_qidx_q;
	logic [IDX_W-1:0]   m_dbidx_q;
	logic [SCORE_W-1:0] m_score_q;
	logic               m_last_q;

	logic [LEN_W-1:0]   eff_len;
	logic               last;
	logic               batch_last;
	op_t                in_op;
	logic               s_fire;
	logic               s1_result;
	logic               s1_fire;
	logic               out_free;
	logic [WORD_W-1:0]  query_word;
	logic [LANES-1:0]   lane_match;
	logic [SCORE_W-1:0] merged_score;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wpv_q    <= WPV_RESET;
			qbase_q  <= '0;
			dbbase_q <= '0;
			dbrows_q <= IDX_W'(1);
		end else if (cfg_valid) begin
			unique case (cfg_reg_t'(cfg_index))
				CFG_WORDS_PER_VECTOR: wpv_q    <= cfg_data[WPV_W-1:0];
				CFG_QUERY_BASE:       qbase_q  <= cfg_data;
				CFG_DB_BASE:          dbbase_q <= cfg_data;
				CFG_DB_ROWS:          dbrows_q <= cfg_data;
			endcase
		end
	end

	always_comb begin
		if (wpv_q == '0) begin
			eff_len = LEN_W'(1);
		end else if (LEN_W'(wpv_q) > LEN_W'(MAX_VECTOR_WORDS)) begin
			eff_len = LEN_W'(MAX_VECTOR_WORDS);
		end else begin
			eff_len = LEN_W'(wpv_q);
		end
	end

	assign in_op      = op_t'(s_tuser);
	assign last       = ((LEN_W + 1)'(pos_q) + (LEN_W + 1)'(1)) >= (LEN_W + 1)'(eff_len);
	assign batch_last = ({1'b0, dbcnt_q} + 33'd1) >= {1'b0, dbrows_q};
	assign s_tready   = !valid_s1;
	assign s_fire     = s_tvalid && s_tready;
	assign out_free   = !m_valid_q || m_tready;
	assign s1_result  = (item_s1.op == OP_COMPARE) && item_s1.last;
	assign s1_fire    = valid_s1 && (!s1_result || out_free);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q   <= '0;
			qcnt_q  <= '1;
			dbcnt_q <= '0;
		end else if (s_fire) begin
			pos_q <= last ? '0 : pos_q + POS_W'(1);
			if (last) begin
				unique case (in_op)
					OP_LOAD: begin
						qcnt_q  <= qcnt_q + IDX_W'(1);
						dbcnt_q <= '0;
					end
					OP_COMPARE: begin
						dbcnt_q <= batch_last ? '0 : dbcnt_q + IDX_W'(1);
					end
				endcase
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_fire) begin
			valid_s1 <= 1'b1;
		end else if (s1_fire) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s_fire) begin
			item_s1.op          <= in_op;
			item_s1.last        <= last;
			item_s1.batch_last  <= batch_last;
			item_s1.query_index <= qbase_q + qcnt_q;
			item_s1.db_index    <= dbbase_q + dbcnt_q;
			item_s1.data_word   <= s_tdata;
		end
	end

	bmse_ram #(
		.WIDTH (WORD_W),
		.DEPTH (MAX_VECTOR_WORDS)
	) u_query_store (
		.clk   (clk),
		.we    (s_fire && (in_op == OP_LOAD)),
		.waddr (pos_q),
		.wdata (s_tdata),
		.re    (s_fire && (in_op == OP_COMPARE)),
		.raddr (pos_q),
		.rdata (query_word)
	);

	for (genvar g = 0; g < LANES; g++) begin : g_lane
		bmse_lane u_lane (
			.query_byte (query_word[g*BYTE_W +: BYTE_W]),
			.db_byte    (item_s1.data_word[g*BYTE_W +: BYTE_W]),
			.match      (lane_match[g])
		);
	end

	bmse_merge u_merge (
		.lane_match (lane_match),
		.acc        (score_q),
		.score      (merged_score)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			score_q <= '0;
		end else if (s1_fire) begin
			if (item_s1.op == OP_LOAD || item_s1.last) begin
				score_q <= '0;
			end else begin
				score_q <= merged_score;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (s1_fire && s1_result) begin
			m_valid_q <= 1'b1;
		end else if (m_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_fire && s1_result) begin
			m_qidx_q  <= item_s1.query_index;
			m_dbidx_q <= item_s1.db_index;
			m_score_q <= merged_score;
			m_last_q  <= item_s1.batch_last;
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tlast  = m_last_q;
	assign m_tdata  = OUT_DATA_W'({m_score_q, m_dbidx_q, m_qidx_q});

	a_fire_stages: assert property (@(posedge clk) disable iff (!arst_n)
		s_fire |=> valid_s1)
		else $error("accepted beat did not reach the compare stage");

	a_pos_wraps: assert property (@(posedge clk) disable iff (!arst_n)
		(s_fire && last) |=> (pos_q == '0))
		else $error("word position did not return to zero after the last word");

	a_score_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(s1_fire && (item_s1.last || item_s1.op == OP_LOAD)) |=> (score_q == '0))
		else $error("running score not cleared at the end of a vector or on a load");

	a_result_held: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && s1_result && !out_free) |=> (valid_s1 && $stable(item_s1)))
		else $error("staged compare beat lost while the output was full");

endmodule
`default_nettype wire

// File: test/tb.sv
`timescale 1ns / 100ps
// Self-checking testbench for byte_match_similarity_engine: predicts every score beat from
// its own model of the query store and counters and compares it field by field.
// Depends on bmse_pkg and the engine RTL only.
module tb;
	import bmse_pkg::*;

	localparam int MAX_WORDS   = 512;
	localparam int ITEM_TARGET = 1850;
	localparam int SETTLE      = 6;

	typedef struct packed {
		logic [IDX_W-1:0]   query_index;
		logic [IDX_W-1:0]   db_index;
		logic [SCORE_W-1:0] score;
		logic               batch_last;
	} score_rec_t;

	logic                  clk;
	logic                  arst_n;
	logic                  s_tvalid;
	logic                  s_tready;
	logic [WORD_W-1:0]     s_tdata;   // data_word
	logic                  s_tuser;   // opcode
	logic                  m_tvalid;
	logic                  m_tready;
	logic [OUT_DATA_W-1:0] m_tdata;   // query_index, db_index, score
	logic                  m_tlast;   // batch_last
	logic                  cfg_valid;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	byte_match_similarity_engine dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tlast   (m_tlast),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	// Shadow of the engine state and registers.
	logic [WORD_W-1:0] qstore [0:MAX_WORDS-1];
	bit                qvalid [0:MAX_WORDS-1];
	int unsigned       wpos;
	int unsigned       rscore;
	logic [IDX_W-1:0]  qcnt;
	logic [IDX_W-1:0]  dbcnt;
	logic [WPV_W-1:0]  cfg_wpv;
	logic [IDX_W-1:0]  cfg_qbase;
	logic [IDX_W-1:0]  cfg_dbbase;
	logic [IDX_W-1:0]  cfg_rows;

	score_rec_t  pending_scores [$];
	int unsigned fail_count;
	int unsigned words_sent;
	int unsigned sink_hold;
	bit          idle_on;

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	initial begin
		#5_000_000;
		$display("TB_ERROR");
		$finish;
	end

	function automatic int unsigned count_equal_bytes(input logic [WORD_W-1:0] a,
			input logic [WORD_W-1:0] b);
		int unsigned n;
		n = 0;
		for (int i = 0; i < LANES; i++)
			if (a[i*BYTE_W +: BYTE_W] == b[i*BYTE_W +: BYTE_W])
				n++;
		return n;
	endfunction

	task automatic apply_word(input op_t op, input logic [WORD_W-1:0] data);
		int unsigned span;
		int unsigned p;
		bit          at_end;
		bit          rows_done;
		score_rec_t  rec;
		span = (cfg_wpv == 0) ? 1 : ((cfg_wpv > MAX_WORDS) ? MAX_WORDS : cfg_wpv);
		p = (wpos >= MAX_WORDS) ? MAX_WORDS - 1 : wpos;
		at_end = (p + 1 >= span);
		if (op == OP_LOAD) begin
			qstore[p] = data;
			qvalid[p] = 1'b1;
			rscore = 0;
			if (at_end) begin
				wpos = 0;
				qcnt = qcnt + 1;
				dbcnt = '0;
			end else begin
				wpos = p + 1;
			end
		end else begin
			rscore += count_equal_bytes(qstore[p], data);
			if (rscore > SCORE_MAX)
				rscore = SCORE_MAX;
			if (!at_end) begin
				wpos = p + 1;
			end else begin
				rows_done = ({1'b0, dbcnt} + 33'd1 >= {1'b0, cfg_rows});
				rec.query_index = cfg_qbase + qcnt;
				rec.db_index = cfg_dbbase + dbcnt;
				rec.score = rscore[SCORE_W-1:0];
				rec.batch_last = rows_done;
				pending_scores.push_back(rec);
				wpos = 0;
				rscore = 0;
				dbcnt = rows_done ? '0 : dbcnt + 1;
			end
		end
	endtask

	function automatic logic [WORD_W-1:0] rand_word();
		int unsigned r;
		r = $urandom_range(0, 9);
		if (r == 0)
			return '0;
		if (r == 1)
			return '1;
		return {$urandom, $urandom};
	endfunction

	// Builds a database word from a stored query word so that scores spread over the range.
	function automatic logic [WORD_W-1:0] probe_word(input logic [WORD_W-1:0] stored);
		logic [WORD_W-1:0] w;
		int unsigned       mode;
		w = stored;
		mode = $urandom_range(0, 5);
		for (int i = 0; i < LANES; i++) begin
			if (mode == 1)
				w[i*BYTE_W +: BYTE_W] = stored[i*BYTE_W +: BYTE_W] ^ 8'($urandom_range(1, 255));
			else if (mode > 1 && $urandom_range(0, 1) == 1)
				w[i*BYTE_W +: BYTE_W] = 8'($urandom_range(0, 255));
		end
		return w;
	endfunction

	task automatic send_word(input op_t op, input logic [WORD_W-1:0] data);
		int unsigned gap;
		@(negedge clk);
		if (idle_on && $urandom_range(0, 4) == 0) begin
			gap = $urandom_range(1, 9);
			s_tvalid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= op;
		s_tdata <= data;
		do @(posedge clk); while (!s_tready);
		apply_word(op, data);
		words_sent++;
	endtask

	// A compare is only sent where the query store holds a word at the current position.
	task automatic send_probe();
		if (qvalid[wpos])
			send_word(OP_COMPARE, probe_word(qstore[wpos]));
		else
			send_word(OP_LOAD, rand_word());
	endtask

	task automatic send_noise();
		if ($urandom_range(0, 1) == 1 && qvalid[wpos])
			send_word(OP_COMPARE, rand_word());
		else
			send_word(OP_LOAD, rand_word());
	endtask

	task automatic load_query();
		do send_word(OP_LOAD, rand_word()); while (wpos != 0);
	endtask

	task automatic score_vector();
		do send_probe(); while (wpos != 0);
	endtask

	task automatic wait_scores_drained();
		@(negedge clk);
		s_tvalid <= 1'b0;
		while (pending_scores.size() != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic write_reg(input cfg_reg_t idx, input logic [CFG_DATA_W-1:0] val);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			CFG_WORDS_PER_VECTOR: cfg_wpv = val[WPV_W-1:0];
			CFG_QUERY_BASE:       cfg_qbase = val;
			CFG_DB_BASE:          cfg_dbbase = val;
			CFG_DB_ROWS:          cfg_rows = val;
			default: ;
		endcase
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	function automatic logic [IDX_W-1:0] pick_index();
		case ($urandom_range(0, 5))
			0: return '0;
			1: return '1;
			2: return 32'hFFFF_FFFF - 32'($urandom_range(0, 3));
			default: return $urandom;
		endcase
	endfunction

	function automatic logic [IDX_W-1:0] pick_rows();
		case ($urandom_range(0, 9))
			0: return '0;
			1: return 32'd1;
			2: return '1;
			default: return 32'($urandom_range(2, 5));
		endcase
	endfunction

	function automatic logic [CFG_DATA_W-1:0] pick_length();
		int unsigned r;
		r = $urandom_range(0, 15);
		if (r == 0)
			return 0;
		if (r == 1)
			return 1;
		if (r <= 11)
			return $urandom_range(2, 6);
		if (r <= 14)
			return $urandom_range(7, 24);
		return $urandom_range(25, 40);
	endfunction

	task automatic test_byte_extremes();
		wait_scores_drained();
		write_reg(CFG_WORDS_PER_VECTOR, 2);
		write_reg(CFG_QUERY_BASE, 32'hFFFF_FFFF);
		write_reg(CFG_DB_BASE, 32'hFFFF_FFFE);
		write_reg(CFG_DB_ROWS, 2);
		send_word(OP_LOAD, '0);
		send_word(OP_LOAD, '1);
		send_word(OP_COMPARE, '0);
		send_word(OP_COMPARE, '1);
		send_word(OP_COMPARE, '1);
		send_word(OP_COMPARE, '0);
		// The batch is used up, so this vector starts again from the first row.
		send_word(OP_COMPARE, 64'h00FF_00FF_00FF_00FF);
		send_word(OP_COMPARE, 64'hFF00_FF00_FF00_FF00);
	endtask

	task automatic test_zero_length_and_rows();
		wait_scores_drained();
		write_reg(CFG_WORDS_PER_VECTOR, 0);
		write_reg(CFG_DB_ROWS, 0);
		load_query();
		score_vector();
		score_vector();
	endtask

	task automatic test_mixed_opcodes();
		wait_scores_drained();
		write_reg(CFG_WORDS_PER_VECTOR, 3);
		write_reg(CFG_DB_ROWS, 3);
		load_query();
		send_word(OP_COMPARE, qstore[0]);
		send_word(OP_LOAD, rand_word());
		send_word(OP_COMPARE, qstore[2]);
		score_vector();
	endtask

	task automatic test_length_shrink();
		wait_scores_drained();
		write_reg(CFG_WORDS_PER_VECTOR, 4);
		load_query();
		send_probe();
		send_probe();
		wait_scores_drained();
		write_reg(CFG_WORDS_PER_VECTOR, 2);
		send_probe();
	endtask

	task automatic test_output_backpressure();
		wait_scores_drained();
		write_reg(CFG_WORDS_PER_VECTOR, 1);
		write_reg(CFG_DB_ROWS, 5);
		load_query();
		sink_hold = 250;
		repeat (40) send_probe();
	endtask

	task automatic test_full_length();
		wait_scores_drained();
		write_reg(CFG_WORDS_PER_VECTOR, MAX_WORDS);
		load_query();
		repeat (MAX_WORDS - 12) send_probe();
		wait_scores_drained();
		write_reg(CFG_WORDS_PER_VECTOR, 1023);
		score_vector();
	endtask

	task automatic test_random_phases();
		int unsigned nvec;
		while (words_sent < ITEM_TARGET) begin
			if (words_sent + 300 > ITEM_TARGET)
				idle_on = 1'b0;
			wait_scores_drained();
			if ($urandom_range(0, 3) != 0)
				write_reg(CFG_WORDS_PER_VECTOR, pick_length());
			if ($urandom_range(0, 1) == 1)
				write_reg(CFG_QUERY_BASE, pick_index());
			if ($urandom_range(0, 1) == 1)
				write_reg(CFG_DB_BASE, pick_index());
			if ($urandom_range(0, 1) == 1)
				write_reg(CFG_DB_ROWS, pick_rows());
			if ($urandom_range(0, 3) != 0)
				load_query();
			nvec = $urandom_range(1, 5);
			repeat (nvec) score_vector();
			if ($urandom_range(0, 3) == 0)
				repeat ($urandom_range(1, 6)) send_noise();
		end
	endtask

	initial begin
		int unsigned gap;
		m_tready = 1'b0;
		gap = 0;
		forever begin
			@(negedge clk);
			if (sink_hold > 0) begin
				m_tready <= 1'b0;
				sink_hold--;
			end else if (gap > 0) begin
				m_tready <= 1'b0;
				gap--;
			end else begin
				m_tready <= 1'b1;
				if (idle_on && $urandom_range(0, 5) == 0)
					gap = $urandom_range(1, 9);
			end
		end
	end

	task automatic compare_field(input string what, input logic [IDX_W-1:0] want,
			input logic [IDX_W-1:0] got);
		if (want !== got) begin
			$display("%0t: %s mismatch, expected %0h, actual %0h", $time, what, want, got);
			fail_count++;
		end
	endtask

	always @(posedge clk) begin
		score_rec_t rec;
		if (arst_n && m_tvalid && m_tready) begin
			if (pending_scores.size() == 0) begin
				$display("%0t: unexpected score beat, expected none, actual %0h last %0b",
					$time, m_tdata, m_tlast);
				fail_count++;
			end else begin
				rec = pending_scores.pop_front();
				compare_field("query_index", rec.query_index, m_tdata[IDX_W-1:0]);
				compare_field("db_index", rec.db_index, m_tdata[2*IDX_W-1:IDX_W]);
				compare_field("score", IDX_W'(rec.score),
					IDX_W'(m_tdata[2*IDX_W+SCORE_W-1:2*IDX_W]));
				compare_field("batch_last", IDX_W'(rec.batch_last), IDX_W'(m_tlast));
			end
		end
	end

	initial begin
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tuser = OP_LOAD;
		s_tdata = '0;
		cfg_valid = 1'b0;
		cfg_index = CFG_WORDS_PER_VECTOR;
		cfg_data = '0;
		wpos = 0;
		rscore = 0;
		qcnt = '1;
		dbcnt = '0;
		cfg_wpv = WPV_RESET;
		cfg_qbase = '0;
		cfg_dbbase = '0;
		cfg_rows = 32'd1;
		fail_count = 0;
		words_sent = 0;
		sink_hold = 0;
		idle_on = 1'b1;
		repeat (8) @(negedge clk);
		arst_n = 1'b1;

		test_byte_extremes();
		test_zero_length_and_rows();
		test_mixed_opcodes();
		test_length_shrink();
		test_output_backpressure();
		test_full_length();
		test_random_phases();

		wait_scores_drained();
		repeat (10) @(posedge clk);
		if (fail_count == 0 && pending_scores.size() == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule

// File: byte_match_similarity_engine.f
hw/rtl/bmse_pkg.sv
hw/rtl/bmse_ram.sv
hw/rtl/bmse_lane.sv
hw/rtl/bmse_merge.sv
hw/rtl/byte_match_similarity_engine.sv
test/tb.sv
